>>> design/hdf_pkg.sv
`timescale 1ns / 1ps

package hdf_pkg;

  // Delimiter (header and tail) limits
  localparam int unsigned MAX_DELIM_LEN = 4;
  localparam int unsigned DELIM_CAP     = (MAX_DELIM_LEN < 4) ? MAX_DELIM_LEN : 4;
  localparam int unsigned MI_W          = 2;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_HDR_LEN = 3'd0,
    REG_HDR_PAT = 3'd1,
    REG_TL_LEN  = 3'd2,
    REG_TL_PAT  = 3'd3,
    REG_CMD_MIN = 3'd4,
    REG_CMD_MAX = 3'd5
  } reg_idx_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_GOOD     = 3'd0,
    ST_BAD_CMD  = 3'd1,
    ST_LEN_BIG  = 3'd2,
    ST_XOR_BAD  = 3'd3,
    ST_TAIL_BAD = 3'd4
  } status_e;

  // Controller states: frame phases, then the emission states
  typedef enum logic [3:0] {
    S_HUNT,
    S_CMD,
    S_LEN,
    S_DATA,
    S_XOR,
    S_TAIL,
    S_RD,
    S_EMIT,
    S_ERR2
  } state_e;

  // Match index operation
  typedef enum logic [1:0] {
    MI_HOLD,
    MI_CLR,
    MI_INC,
    MI_ONE
  } mi_op_e;

  // Result register source
  typedef enum logic [2:0] {
    OSEL_BADCMD_IN,
    OSEL_BADCMD_PEND,
    OSEL_LEN_BIG,
    OSEL_FRAME,
    OSEL_DATA
  } osel_e;

  // Effective configuration as seen by the datapath
  typedef struct packed {
    logic [2:0]  hdr_len;
    logic [31:0] hdr_pat;
    logic [2:0]  tl_len;
    logic [31:0] tl_pat;
    logic [7:0]  cmd_min;
    logic [7:0]  cmd_max;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    mi_op_e  match_op;
    logic    cmd_load;
    logic    len_load;
    logic    data_wr;
    logic    pend_load;
    logic    rd_clr;
    logic    rd_inc;
    logic    out_load;
    osel_e   osel;
    status_e status;
    logic    last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hl_zero;
    logic hl_one;
    logic hdr_match;
    logic hdr0_match;
    logic hdr_done;
    logic cmd_ok;
    logic len_big;
    logic len_zero;
    logic data_done;
    logic xor_ok;
    logic tl_zero;
    logic tail_match;
    logic tail_done;
    logic frame_empty;
    logic rd_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> design/hdf_ram.sv
`timescale 1ns / 1ps

module hdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/hdf_ctrl.sv
`timescale 1ns / 1ps

module hdf_ctrl import hdf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    mode_i,
  input  dp_sts_t sts_i,
  output logic    in_stall_o,
  output dp_cmd_t cmd_o
);

  // a tail mismatch can be followed by a second result only if two fit
  localparam bit TWO_RES = (MAX_PAYLOAD >= 2);

  state_e state_q, state_d;
  logic   busy;
  logic   accept;
  logic   take;
  logic   good;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    take    = 1'b0;
    good    = 1'b0;
    busy    = (state_q == S_RD) || (state_q == S_EMIT) || (state_q == S_ERR2);
    in_stall_o = busy || !sts_i.out_free;
    accept  = in_valid_i && !in_stall_o;

    unique case (state_q)
      S_RD: begin
        // read address presented, data registered for next cycle
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.osel     = OSEL_DATA;
          cmd_o.status   = ST_GOOD;
          cmd_o.last     = sts_i.rd_last;
          if (sts_i.rd_last) begin
            state_d = S_HUNT;
          end else begin
            cmd_o.rd_inc = 1'b1;
            state_d      = S_RD;
          end
        end
      end
      S_ERR2: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.osel     = OSEL_BADCMD_PEND;
          cmd_o.status   = ST_BAD_CMD;
          cmd_o.last     = 1'b1;
          state_d        = S_HUNT;
        end
      end
      default: begin
        if (accept) begin
          if (mode_i) begin
            // abort: back to the header hunt
            state_d        = S_HUNT;
            cmd_o.match_op = MI_CLR;
          end else begin
            unique case (state_q)
              S_HUNT: begin
                if (sts_i.hl_zero) begin
                  take = 1'b1;
                end else if (sts_i.hdr_match) begin
                  if (sts_i.hdr_done) begin
                    cmd_o.match_op = MI_CLR;
                    state_d        = S_CMD;
                  end else begin
                    cmd_o.match_op = MI_INC;
                  end
                end else begin
                  cmd_o.match_op = MI_CLR;
                end
              end
              S_CMD: begin
                take = 1'b1;
              end
              S_LEN: begin
                if (sts_i.len_big) begin
                  cmd_o.out_load = 1'b1;
                  cmd_o.osel     = OSEL_LEN_BIG;
                  cmd_o.status   = ST_LEN_BIG;
                  cmd_o.last     = 1'b1;
                  cmd_o.match_op = MI_CLR;
                  state_d        = S_HUNT;
                end else begin
                  cmd_o.len_load = 1'b1;
                  state_d        = sts_i.len_zero ? S_XOR : S_DATA;
                end
              end
              S_DATA: begin
                cmd_o.data_wr = 1'b1;
                if (sts_i.data_done) begin
                  state_d = S_XOR;
                end
              end
              S_XOR: begin
                if (!sts_i.xor_ok) begin
                  cmd_o.out_load = 1'b1;
                  cmd_o.osel     = OSEL_FRAME;
                  cmd_o.status   = ST_XOR_BAD;
                  cmd_o.last     = 1'b1;
                  cmd_o.match_op = MI_CLR;
                  state_d        = S_HUNT;
                end else if (sts_i.tl_zero) begin
                  good = 1'b1;
                end else begin
                  cmd_o.match_op = MI_CLR;
                  state_d        = S_TAIL;
                end
              end
              S_TAIL: begin
                if (sts_i.tail_match) begin
                  if (sts_i.tail_done) begin
                    good = 1'b1;
                  end else begin
                    cmd_o.match_op = MI_INC;
                  end
                end else begin
                  // tail error; byte then checked as header or command byte
                  cmd_o.out_load = 1'b1;
                  cmd_o.osel     = OSEL_FRAME;
                  cmd_o.status   = ST_TAIL_BAD;
                  cmd_o.last     = !(sts_i.hl_zero && !sts_i.cmd_ok && TWO_RES);
                  cmd_o.match_op = MI_CLR;
                  state_d        = S_HUNT;
                  if (sts_i.hl_zero) begin
                    if (sts_i.cmd_ok) begin
                      cmd_o.cmd_load = 1'b1;
                      state_d        = S_LEN;
                    end else if (TWO_RES) begin
                      cmd_o.pend_load = 1'b1;
                      state_d         = S_ERR2;
                    end
                  end else if (sts_i.hdr0_match) begin
                    if (sts_i.hl_one) begin
                      state_d = S_CMD;
                    end else begin
                      cmd_o.match_op = MI_ONE;
                    end
                  end
                end
              end
              default: begin
                state_d = S_HUNT;
              end
            endcase

            // command byte check
            if (take) begin
              if (sts_i.cmd_ok) begin
                cmd_o.cmd_load = 1'b1;
                state_d        = S_LEN;
              end else begin
                cmd_o.out_load = 1'b1;
                cmd_o.osel     = OSEL_BADCMD_IN;
                cmd_o.status   = ST_BAD_CMD;
                cmd_o.last     = 1'b1;
                cmd_o.match_op = MI_CLR;
                state_d        = S_HUNT;
              end
            end

            // good frame: empty result at once, else start the payload burst
            if (good) begin
              cmd_o.match_op = MI_CLR;
              if (sts_i.frame_empty) begin
                cmd_o.out_load = 1'b1;
                cmd_o.osel     = OSEL_FRAME;
                cmd_o.status   = ST_GOOD;
                cmd_o.last     = 1'b1;
                state_d        = S_HUNT;
              end else begin
                cmd_o.rd_clr = 1'b1;
                state_d      = S_RD;
              end
            end
          end
        end
      end
    endcase
  end

endmodule

>>> design/hdf_dp.sv
`timescale 1ns / 1ps

module hdf_dp import hdf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  dp_cmd_t     cmd_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_stall_i,
  output dp_sts_t     sts_o,
  output logic        out_valid_o,
  output logic [2:0]  status_o,
  output logic [7:0]  command_o,
  output logic [6:0]  frame_length_o,
  output logic [5:0]  data_index_o,
  output logic [7:0]  data_byte_o,
  output logic        data_valid_o,
  output logic        last_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // frame state
  logic [MI_W-1:0] match_q, match_d;
  logic [7:0]      held_cmd_q;
  logic [6:0]      exp_len_q;
  logic [6:0]      rcv_cnt_q;
  logic [7:0]      xor_q;
  logic [5:0]      rd_idx_q;
  logic [7:0]      pend_cmd_q;
  logic [7:0]      ram_rdata;

  // result register
  logic            out_valid_q;
  logic [2:0]      status_q;
  logic [7:0]      command_q, command_d;
  logic [6:0]      frame_length_q, frame_length_d;
  logic [5:0]      data_index_q, data_index_d;
  logic [7:0]      data_byte_q, data_byte_d;
  logic            data_valid_q, data_valid_d;
  logic            last_q;

  logic [2:0]      hl_eff;
  logic [2:0]      tl_eff;
  logic [2:0]      match_nxt;
  logic [7:0]      hdr_byte;
  logic [7:0]      tl_byte;

  // effective delimiter lengths and current pattern bytes
  always_comb begin
    hl_eff    = (cfg_i.hdr_len > 3'(DELIM_CAP)) ? 3'(DELIM_CAP) : cfg_i.hdr_len;
    tl_eff    = (cfg_i.tl_len > 3'(DELIM_CAP)) ? 3'(DELIM_CAP) : cfg_i.tl_len;
    match_nxt = 3'({1'b0, match_q}) + 3'd1;
    hdr_byte  = cfg_i.hdr_pat[8*match_q +: 8];
    tl_byte   = cfg_i.tl_pat[8*match_q +: 8];
  end

  // status to the controller
  always_comb begin
    sts_o.hl_zero     = (hl_eff == 3'd0);
    sts_o.hl_one      = (hl_eff == 3'd1);
    sts_o.hdr_match   = (rx_byte_i == hdr_byte);
    sts_o.hdr0_match  = (rx_byte_i == cfg_i.hdr_pat[7:0]);
    sts_o.hdr_done    = (match_nxt >= hl_eff);
    sts_o.cmd_ok      = (rx_byte_i >= cfg_i.cmd_min) && (rx_byte_i <= cfg_i.cmd_max);
    sts_o.len_big     = (rx_byte_i > 8'(MAX_PAYLOAD));
    sts_o.len_zero    = (rx_byte_i == 8'd0);
    sts_o.data_done   = ((rcv_cnt_q + 7'd1) >= exp_len_q);
    sts_o.xor_ok      = (rx_byte_i == xor_q);
    sts_o.tl_zero     = (tl_eff == 3'd0);
    sts_o.tail_match  = (rx_byte_i == tl_byte);
    sts_o.tail_done   = (match_nxt >= tl_eff);
    sts_o.frame_empty = (exp_len_q == 7'd0);
    sts_o.rd_last     = ((7'({1'b0, rd_idx_q}) + 7'd1) == exp_len_q);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // match index
  always_comb begin
    unique case (cmd_i.match_op)
      MI_CLR:  match_d = '0;
      MI_INC:  match_d = match_nxt[MI_W-1:0];
      MI_ONE:  match_d = MI_W'(1);
      default: match_d = match_q;
    endcase
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q    <= '0;
      held_cmd_q <= '0;
      exp_len_q  <= '0;
      rcv_cnt_q  <= '0;
      xor_q      <= '0;
      rd_idx_q   <= '0;
    end else begin
      match_q <= match_d;
      if (cmd_i.cmd_load) begin
        held_cmd_q <= rx_byte_i;
      end
      if (cmd_i.len_load) begin
        exp_len_q <= rx_byte_i[6:0];
        rcv_cnt_q <= '0;
        xor_q     <= '0;
      end else if (cmd_i.data_wr) begin
        rcv_cnt_q <= rcv_cnt_q + 7'd1;
        xor_q     <= xor_q ^ rx_byte_i;
      end
      if (cmd_i.rd_clr) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_inc) begin
        rd_idx_q <= rd_idx_q + 6'd1;
      end
    end
  end

  // rejected command waiting behind a tail error
  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_cmd_q <= rx_byte_i;
    end
  end

  // payload store
  hdf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.data_wr),
    .waddr_i (rcv_cnt_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload selection
  always_comb begin
    command_d      = held_cmd_q;
    frame_length_d = exp_len_q;
    data_index_d   = '0;
    data_byte_d    = '0;
    data_valid_d   = 1'b0;
    unique case (cmd_i.osel)
      OSEL_BADCMD_IN: begin
        command_d      = rx_byte_i;
        frame_length_d = '0;
      end
      OSEL_BADCMD_PEND: begin
        command_d      = pend_cmd_q;
        frame_length_d = '0;
      end
      OSEL_LEN_BIG: begin
        frame_length_d = rx_byte_i[7] ? 7'h7f : rx_byte_i[6:0];
      end
      OSEL_DATA: begin
        data_index_d = rd_idx_q;
        data_byte_d  = ram_rdata;
        data_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q       <= cmd_i.status;
      last_q         <= cmd_i.last;
      command_q      <= command_d;
      frame_length_q <= frame_length_d;
      data_index_q   <= data_index_d;
      data_byte_q    <= data_byte_d;
      data_valid_q   <= data_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign command_o      = command_q;
  assign frame_length_o = frame_length_q;
  assign data_index_o   = data_index_q;
  assign data_byte_o    = data_byte_q;
  assign data_valid_o   = data_valid_q;
  assign last_o         = last_q;

endmodule

>>> design/header_cmd_len_xor_tail_deframer_top.sv
// Channel   Direction  Handshake                     Payload
// in        input      in_valid_i / in_stall_o       mode_i, rx_byte_i
// out       output     out_valid_o / out_stall_i     status_o .. last_o
// cfg       APB write  psel, penable, pwrite, pready paddr, pwdata (prdata on read)
//
// A received byte or abort is taken whenever in_stall_o is low.
// A good frame of N payload bytes emits N results, each by a registered payload store
// read (S_RD) and then a result register load (S_EMIT).
// A tail error followed by a rejected command gives a second result, loaded from S_ERR2.
// Reset (rst_ni low, asynchronous) clears configuration to defaults and restarts the header hunt.
// Input stalls during a payload burst or a second error result and while a result is stalled.
`timescale 1ns / 1ps

module header_cmd_len_xor_tail_deframer_top import hdf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // received bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  command_o,
  output logic [6:0]  frame_length_o,
  output logic [5:0]  data_index_o,
  output logic [7:0]  data_byte_o,
  output logic        data_valid_o,
  output logic        last_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0]  hdr_len_q;
  logic [31:0] hdr_pat_q;
  logic [2:0]  tl_len_q;
  logic [31:0] tl_pat_q;
  logic [7:0]  cmd_min_q;
  logic [7:0]  cmd_max_q;
  logic        cfg_wr;
  reg_idx_e    reg_idx;
  cfg_t        cfg;
  dp_cmd_t     dp_cmd;
  dp_sts_t     dp_sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_len_q <= '0;
      hdr_pat_q <= '0;
      tl_len_q  <= '0;
      tl_pat_q  <= '0;
      cmd_min_q <= '0;
      cmd_max_q <= 8'hff;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HDR_LEN: hdr_len_q <= pwdata[2:0];
        REG_HDR_PAT: hdr_pat_q <= pwdata;
        REG_TL_LEN:  tl_len_q  <= pwdata[2:0];
        REG_TL_PAT:  tl_pat_q  <= pwdata;
        REG_CMD_MIN: cmd_min_q <= pwdata[7:0];
        REG_CMD_MAX: cmd_max_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      REG_HDR_LEN: prdata = {29'd0, hdr_len_q};
      REG_HDR_PAT: prdata = hdr_pat_q;
      REG_TL_LEN:  prdata = {29'd0, tl_len_q};
      REG_TL_PAT:  prdata = tl_pat_q;
      REG_CMD_MIN: prdata = {24'd0, cmd_min_q};
      REG_CMD_MAX: prdata = {24'd0, cmd_max_q};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    cfg.hdr_len = hdr_len_q;
    cfg.hdr_pat = hdr_pat_q;
    cfg.tl_len  = tl_len_q;
    cfg.tl_pat  = tl_pat_q;
    cfg.cmd_min = cmd_min_q;
    cfg.cmd_max = cmd_max_q;
  end

  // frame sequencer
  hdf_ctrl #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .sts_i      (dp_sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (dp_cmd)
  );

  // frame state, payload store and result register
  hdf_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (dp_cmd),
    .rx_byte_i      (rx_byte_i),
    .out_stall_i    (out_stall_i),
    .sts_o          (dp_sts),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .command_o      (command_o),
    .frame_length_o (frame_length_o),
    .data_index_o   (data_index_o),
    .data_byte_o    (data_byte_o),
    .data_valid_o   (data_valid_o),
    .last_o         (last_o)
  );

`ifndef SYNTHESIS
  // no byte taken while a held result is stalled
  a_no_accept_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(out_valid_o && out_stall_i))
    else $error("byte taken while result register full");

  // payload bytes only in good-frame results
  a_data_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && data_valid_o) |-> (status_o == ST_GOOD))
    else $error("payload byte in an error result");

  // results without data carry zero index and byte
  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !data_valid_o) |-> (data_index_o == 6'd0 && data_byte_o == 8'd0))
    else $error("stray data in a result without payload");

  // emitted index lies inside the frame
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && data_valid_o) |-> ({1'b0, data_index_o} < frame_length_o))
    else $error("payload index beyond frame length");
`endif

endmodule
